FILE: hdl/tts_pkg.sv
// Shared types, codes and constants for the table-driven token splitter.
`default_nettype none

package tts_pkg;

    // Default number of transition table slots
    localparam int TABLE_DEPTH_DEF = 32;

    // Token length saturation for the buffer size limit
    localparam int LEN_CAP = 4096;

    // Request command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;
    localparam logic [1:0] CMD_END   = 2'd3;

    // One transition table entry
    typedef struct packed {
        logic [7:0] st;
        logic [7:0] ch;
        logic       any;
        logic [7:0] nxt;
        logic       keep;
        logic       skip;
    } tts_entry_t;

    // One result
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_kept;
        logic       token_end;
        logic [7:0] state_out;
        logic       too_long;
    } tts_res_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_entry;
        logic begin_tok;
        logic end_tok;
        logic start_scan;
        logic step;
        logic finish;
        logic finish_hit;
        logic post;
    } tts_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic n_zero;
        logic match;
        logic last;
    } tts_stat_t;

endpackage

`default_nettype wire

FILE: hdl/tts_dp.sv
// Datapath: transition table memory, lexer state, token length and result registers.
`default_nettype none

module tts_dp #(
    parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tts_pkg::tts_ctrl_t ctrl,
    output tts_pkg::tts_stat_t     stat,
    input  wire logic [5:0]        entry_count,
    input  wire logic [12:0]       buffer_size,
    input  wire logic [4:0]        entry_index,
    input  wire logic [7:0]        entry_state,
    input  wire logic [7:0]        entry_char,
    input  wire logic              entry_any,
    input  wire logic [7:0]        entry_next,
    input  wire logic              entry_keep,
    input  wire logic              entry_skip,
    input  wire logic [7:0]        start_state,
    input  wire logic [7:0]        char_in,
    output logic [7:0]             out_char,
    output logic                   char_kept,
    output logic                   token_end,
    output logic [7:0]             state_out,
    output logic                   too_long
);
    import tts_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);

    tts_entry_t tbl_mem [TABLE_DEPTH];
    tts_entry_t rd_reg;
    tts_entry_t wr_entry;

    logic [7:0]    state_reg;
    logic [11:0]   len_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    char_reg;
    tts_res_t      res_reg;
    tts_res_t      out_res_reg;

    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_in_range;
    logic [CW-1:0]    n_lim;

    logic        kept;
    logic        ended;
    logic        flag;
    logic [7:0]  state_next;
    logic [11:0] len_next;
    logic [12:0] len_sum;
    logic [12:0] lim;
    tts_res_t    fin_res;
    tts_res_t    end_res;

    // Assemble the entry and its slot address
    assign wr_entry    = '{st: entry_state, ch: entry_char, any: entry_any,
                           nxt: entry_next, keep: entry_keep, skip: entry_skip};
    assign wr_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
    assign wr_addr     = IDX_W'(entry_index);
    assign rd_addr     = IDX_W'(cnt_reg);

    // Clamp the searched entry count to the table depth
    always_comb
    begin
        if (32'(entry_count) > 32'(TABLE_DEPTH))
        begin
            n_lim = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_lim = CW'(entry_count);
        end
    end

    // Report scan status
    assign stat.n_zero = (n_lim == '0);
    assign stat.last   = (cnt_reg == n_lim);
    assign stat.match  = (rd_reg.st == state_reg) && (rd_reg.any || (rd_reg.ch == char_reg));

    // Resolve the character against the hit entry, if any
    always_comb
    begin
        kept       = !ctrl.finish_hit || rd_reg.keep;
        ended      = ctrl.finish_hit && !rd_reg.keep && !rd_reg.skip;
        state_next = ctrl.finish_hit ? rd_reg.nxt : state_reg;
        lim        = (buffer_size > 13'(LEN_CAP)) ? 13'(LEN_CAP) : buffer_size;
        len_sum    = {1'b0, len_reg} + {12'd0, kept};
        flag       = !ended && (len_sum >= lim);
        len_next   = (ended || flag) ? 12'd0 : len_sum[11:0];
        fin_res    = '{out_char: char_reg, char_kept: kept, token_end: ended,
                       state_out: state_next, too_long: flag};
        end_res    = '{out_char: 8'd0, char_kept: 1'b0, token_end: 1'b1,
                       state_out: state_reg, too_long: 1'b0};
    end

    // Write the table and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_entry && wr_in_range)
        begin
            tbl_mem[wr_addr] <= wr_entry;
        end
        rd_reg <= tbl_mem[rd_addr];
    end

    // Hold lexer state, token length and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 8'd0;
            len_reg   <= 12'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (ctrl.begin_tok)
            begin
                state_reg <= start_state;
                len_reg   <= 12'd0;
            end
            if (ctrl.end_tok)
            begin
                len_reg <= 12'd0;
            end
            if (ctrl.start_scan)
            begin
                cnt_reg <= '0;
            end
            if (ctrl.step)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (ctrl.finish)
            begin
                state_reg <= state_next;
                len_reg   <= len_next;
            end
        end
    end

    // Capture the character, park the result, load the output register
    always_ff @(posedge clk)
    begin
        if (ctrl.start_scan)
        begin
            char_reg <= char_in;
        end
        if (ctrl.finish)
        begin
            res_reg <= fin_res;
        end
        if (ctrl.end_tok)
        begin
            res_reg <= end_res;
        end
        if (ctrl.post)
        begin
            out_res_reg <= res_reg;
        end
    end

    assign out_char  = out_res_reg.out_char;
    assign char_kept = out_res_reg.char_kept;
    assign token_end = out_res_reg.token_end;
    assign state_out = out_res_reg.state_out;
    assign too_long  = out_res_reg.too_long;

endmodule

`default_nettype wire

FILE: hdl/tts_ctrl.sv
// Controller: sequences table writes, token commands, the table scan and result posting.
`default_nettype none

module tts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tts_pkg::tts_ctrl_t      ctrl,
    input  wire tts_pkg::tts_stat_t stat
);
    import tts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_POST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Decode the next state and the datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_WRITE: ctrl.wr_entry  = 1'b1;
                        CMD_BEGIN: ctrl.begin_tok = 1'b1;
                        CMD_END:
                        begin
                            ctrl.end_tok = 1'b1;
                            state_next   = S_POST;
                        end
                        CMD_CHAR:
                        begin
                            ctrl.start_scan = 1'b1;
                            state_next      = S_FETCH;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (stat.n_zero)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_POST;
                end
                else
                begin
                    ctrl.step  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.match)
                begin
                    ctrl.finish     = 1'b1;
                    ctrl.finish_hit = 1'b1;
                    state_next      = S_POST;
                end
                else if (stat.last)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = S_POST;
                end
                else
                begin
                    ctrl.step = 1'b1;
                end
            end
            S_POST:
            begin
                if (slot_free)
                begin
                    ctrl.post  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set output valid on a post, drop it when the result is taken
    always_comb
    begin
        priority if (ctrl.post)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is posted only into a free output register
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.post |-> slot_free)
        else $error("result posted over an unread result");

    // A character request starts the scan with a fetch
    a_char_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_CHAR)) |=> (state_reg == S_FETCH))
        else $error("character request did not start the scan");

    // A finished item is posted before the next request is taken
    a_finish_post: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.finish |=> ((state_reg == S_POST) && !in_ready))
        else $error("finished item not held for posting");

    // Scan steps only while fetching or checking
    a_step_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |-> ((state_reg == S_FETCH) || (state_reg == S_CHECK)))
        else $error("scan step outside the scan");

endmodule

`default_nettype wire

FILE: hdl/table_driven_token_splitter.sv
// Top level: configuration registers, controller and datapath of the token splitter.
//
//  Channel  Dir  Handshake            Payload
//  in       in   in_valid/in_ready    cmd, entry_*, start_state, char_in
//  out      out  out_valid/out_ready  out_char, char_kept, token_end, state_out, too_long
//  cfg      in   APB psel/penable     paddr[2] selects entry_count or buffer_size
//
// Write and begin requests finish on acceptance; end of input also passes through the post step.
// A character is fetched, then checked against the table entries in order up to and
// including the first hit, or all min(entry_count, TABLE_DEPTH) when none hits, then posted:
// the table has one read port and the scan reads one entry per cycle.
// Reset clears state, token length and registers; the table is not cleared.
// The output register holds a result while the next request is accepted; a new
// result waits in the post step until the previous one is taken.
`default_nettype none

module table_driven_token_splitter #(
    parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [4:0]  entry_index,
    input  wire logic [7:0]  entry_state,
    input  wire logic [7:0]  entry_char,
    input  wire logic        entry_any,
    input  wire logic [7:0]  entry_next,
    input  wire logic        entry_keep,
    input  wire logic        entry_skip,
    input  wire logic [7:0]  start_state,
    input  wire logic [7:0]  char_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_char,
    output logic             char_kept,
    output logic             token_end,
    output logic [7:0]       state_out,
    output logic             too_long,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tts_pkg::*;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_BUFFER_SIZE = 1'b1;

    logic [5:0]  entry_count_reg;
    logic [12:0] buffer_size_reg;
    logic        cfg_wr;
    tts_ctrl_t   ctrl;
    tts_stat_t   stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 6'd0;
            buffer_size_reg <= 13'd64;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ENTRY_COUNT: entry_count_reg <= pwdata[5:0];
                REG_BUFFER_SIZE: buffer_size_reg <= pwdata[12:0];
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (paddr[2])
            REG_ENTRY_COUNT: prdata = {26'd0, entry_count_reg};
            REG_BUFFER_SIZE: prdata = {19'd0, buffer_size_reg};
        endcase
    end

    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    tts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .entry_count (entry_count_reg),
        .buffer_size (buffer_size_reg),
        .entry_index (entry_index),
        .entry_state (entry_state),
        .entry_char  (entry_char),
        .entry_any   (entry_any),
        .entry_next  (entry_next),
        .entry_keep  (entry_keep),
        .entry_skip  (entry_skip),
        .start_state (start_state),
        .char_in     (char_in),
        .out_char    (out_char),
        .char_kept   (char_kept),
        .token_end   (token_end),
        .state_out   (state_out),
        .too_long    (too_long)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the table-driven token splitter.
`timescale 1ns / 1ps

module tb;
    import tts_pkg::*;

    localparam int TABLE_SLOTS = 32;
    localparam int DRAIN_CYCLES = 48;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX = 10;
    localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;
    localparam logic [2:0] ADDR_BUFFER_SIZE = 3'd4;

    // One request on the input channel
    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] idx;
        tts_entry_t ent;
        logic [7:0] start;
        logic [7:0] ch;
    } tok_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    tok_req_t cur_req = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_char;
    logic char_kept;
    logic token_end;
    logic [7:0] state_out;
    logic too_long;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Predictor copy of the lexer state and registers
    tts_entry_t lex_table [TABLE_SLOTS];
    logic [7:0] cur_state = '0;
    logic [11:0] tok_len = '0;
    logic [5:0] cfg_count = 6'd0;
    logic [12:0] cfg_bufsize = 13'd64;

    tok_req_t pend_req_q [$];
    tts_res_t token_exp_q [$];

    int send_gap = 0;
    int rx_wait = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int cyc_cnt = 0;
    int err_cnt = 0;
    int n_writes = 0;
    int n_begins = 0;
    int n_chars = 0;
    int n_ends = 0;
    int n_tok_ends = 0;
    int n_overflow = 0;
    int n_settings = 0;

    table_driven_token_splitter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cur_req.cmd),
        .entry_index (cur_req.idx),
        .entry_state (cur_req.ent.st),
        .entry_char  (cur_req.ent.ch),
        .entry_any   (cur_req.ent.any),
        .entry_next  (cur_req.ent.nxt),
        .entry_keep  (cur_req.ent.keep),
        .entry_skip  (cur_req.ent.skip),
        .start_state (cur_req.start),
        .char_in     (cur_req.ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .char_kept   (char_kept),
        .token_end   (token_end),
        .state_out   (state_out),
        .too_long    (too_long),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up at the cycle limit
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc_cnt,
                     token_exp_q.size());
            $display("table_driven_token_splitter test failed");
            $finish;
        end
    end

    // Apply one request to the predicted lexer; return 1 when it yields a token result
    function automatic bit lex_step(input tok_req_t r, output tts_res_t res);
        int hit;
        int n;
        int lim;
        int len;
        bit kept;
        bit ended;
        bit flagged;
        res = '0;
        case (r.cmd)
            CMD_WRITE:
            begin
                lex_table[r.idx] = r.ent;
                n_writes++;
                return 1'b0;
            end
            CMD_BEGIN:
            begin
                cur_state = r.start;
                tok_len = '0;
                n_begins++;
                return 1'b0;
            end
            CMD_END:
            begin
                tok_len = '0;
                res.token_end = 1'b1;
                res.state_out = cur_state;
                n_ends++;
                return 1'b1;
            end
            default:
            begin
                // First in-use entry that matches state and character decides
                hit = -1;
                n = (cfg_count > TABLE_SLOTS) ? TABLE_SLOTS : cfg_count;
                for (int i = 0; i < n; i++)
                begin
                    if (hit < 0 && lex_table[i].st == cur_state &&
                        (lex_table[i].any || lex_table[i].ch == r.ch))
                        hit = i;
                end
                kept = 1'b1;
                ended = 1'b0;
                flagged = 1'b0;
                if (hit >= 0)
                begin
                    cur_state = lex_table[hit].nxt;
                    kept = lex_table[hit].keep;
                    ended = !lex_table[hit].keep && !lex_table[hit].skip;
                end
                if (ended)
                    tok_len = '0;
                else
                begin
                    lim = (cfg_bufsize > LEN_CAP) ? LEN_CAP : int'(cfg_bufsize);
                    len = int'(tok_len) + (kept ? 1 : 0);
                    if (len >= lim)
                    begin
                        flagged = 1'b1;
                        tok_len = '0;
                    end
                    else
                        tok_len = len[11:0];
                end
                res.out_char = r.ch;
                res.char_kept = kept;
                res.token_end = ended;
                res.state_out = cur_state;
                res.too_long = flagged;
                n_chars++;
                if (ended)
                    n_tok_ends++;
                if (flagged)
                    n_overflow++;
                return 1'b1;
            end
        endcase
    endfunction

    // Driver: offer pending requests, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin : drv_blk
        tok_req_t r;
        tts_res_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (lex_step(cur_req, res))
                    token_exp_q.push_back(res);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pend_req_q.size() != 0)
                begin
                    r = pend_req_q.pop_front();
                    cur_req <= r;
                    in_valid <= 1'b1;
                    send_gap <= tx_quiet ? 0 : $urandom_range(0, 14);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req && hold_left == 0)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: take results, compare with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        tts_res_t got;
        tts_res_t want;
        int w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            w = rx_wait;
            if (out_valid && out_ready)
            begin
                got = {out_char, char_kept, token_end, state_out, too_long};
                if (token_exp_q.size() == 0)
                begin
                    if (err_cnt < REPORT_MAX)
                        $display("unexpected result: char %h kept %b end %b state %h long %b",
                                 got.out_char, got.char_kept, got.token_end, got.state_out,
                                 got.too_long);
                    err_cnt++;
                end
                else
                begin
                    want = token_exp_q.pop_front();
                    if (got.out_char !== want.out_char || got.char_kept !== want.char_kept ||
                        got.token_end !== want.token_end ||
                        got.state_out !== want.state_out || got.too_long !== want.too_long)
                    begin
                        if (err_cnt < REPORT_MAX)
                        begin
                            $display("mismatch exp: char %h kept %b end %b state %h long %b",
                                     want.out_char, want.char_kept, want.token_end,
                                     want.state_out, want.too_long);
                            $display("         got: char %h kept %b end %b state %h long %b",
                                     got.out_char, got.char_kept, got.token_end,
                                     got.state_out, got.too_long);
                        end
                        err_cnt++;
                    end
                end
                w = rx_quiet ? 0 : $urandom_range(0, 14);
            end
            else if (!out_ready && w != 0)
                w = w - 1;
            rx_wait <= w;
            out_ready <= (w == 0) && (hold_left == 0);
        end
    end

    // Request builders
    function automatic tok_req_t make_write(input int idx, input int st, input int ch,
                                            input bit any, input int nxt, input bit keep,
                                            input bit skip);
        tok_req_t r;
        r = '0;
        r.cmd = CMD_WRITE;
        r.idx = idx[4:0];
        r.ent.st = st[7:0];
        r.ent.ch = ch[7:0];
        r.ent.any = any;
        r.ent.nxt = nxt[7:0];
        r.ent.keep = keep;
        r.ent.skip = skip;
        return r;
    endfunction

    function automatic tok_req_t make_char(input int ch);
        tok_req_t r;
        r = '0;
        r.cmd = CMD_CHAR;
        r.ch = ch[7:0];
        return r;
    endfunction

    function automatic tok_req_t make_begin(input int st);
        tok_req_t r;
        r = '0;
        r.cmd = CMD_BEGIN;
        r.start = st[7:0];
        return r;
    endfunction

    function automatic tok_req_t make_end();
        tok_req_t r;
        r = '0;
        r.cmd = CMD_END;
        return r;
    endfunction

    // Small alphabet so table entries match often
    function automatic int pick_char();
        case ($urandom_range(0, 7))
            0: return 8'h20;
            1: return 8'h2C;
            2: return 8'h61;
            3: return 8'h41;
            4: return 8'h30;
            5: return 8'h0A;
            6: return 8'hFF;
            default: return 8'h80;
        endcase
    endfunction

    // Mostly a handful of live states, sometimes any state
    function automatic int pick_state();
        if ($urandom_range(0, 4) != 0)
            return $urandom_range(0, 3);
        return $urandom_range(0, 255);
    endfunction

    function automatic tok_req_t random_request();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 62)
            return make_char(($urandom_range(0, 4) != 0) ? pick_char() : $urandom_range(1, 255));
        if (sel < 72)
            return make_end();
        if (sel < 82)
            return make_begin(pick_state());
        return make_write($urandom_range(0, 31), pick_state(),
                          ($urandom_range(0, 3) != 0) ? pick_char() : $urandom_range(0, 255),
                          $urandom_range(0, 4) == 0, pick_state(),
                          $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
    endfunction

    // Register write: setup cycle, then access cycle
    task automatic cfg_write(input logic [2:0] addr, input int data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until no request is pending and no result is expected, then let the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pend_req_q.size() != 0 || in_valid || token_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_cfg(input int count, input int bsize);
        wait_idle();
        cfg_write(ADDR_ENTRY_COUNT, count);
        cfg_write(ADDR_BUFFER_SIZE, bsize);
        cfg_count = count[5:0];
        cfg_bufsize = bsize[12:0];
        n_settings++;
    endtask

    task automatic random_phase(input int count, input int bsize, input int nreq,
                                input bit quiet_tx, input bit quiet_rx);
        apply_cfg(count, bsize);
        @(negedge clk);
        tx_quiet = quiet_tx;
        rx_quiet = quiet_rx;
        for (int i = 0; i < nreq; i++)
            pend_req_q.push_back(random_request());
    endtask

    initial
    begin : stim
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        apply_cfg(32, 4);
        @(negedge clk);
        // Load every slot so no scan reads an unwritten entry
        pend_req_q.push_back(make_write(0, 0, 8'h20, 1'b0, 0, 1'b0, 1'b1));
        pend_req_q.push_back(make_write(1, 0, 8'h2C, 1'b0, 1, 1'b0, 1'b0));
        pend_req_q.push_back(make_write(2, 1, 8'h00, 1'b1, 0, 1'b1, 1'b0));
        pend_req_q.push_back(make_write(3, 0, 8'h78, 1'b0, 2, 1'b1, 1'b1));
        pend_req_q.push_back(make_write(4, 2, 8'hFF, 1'b0, 8'hFF, 1'b0, 1'b0));
        pend_req_q.push_back(make_write(5, 8'hFF, 8'h00, 1'b1, 0, 1'b0, 1'b0));
        pend_req_q.push_back(make_write(6, 0, 8'h2C, 1'b0, 3, 1'b1, 1'b0));
        for (int i = 7; i < TABLE_SLOTS; i++)
            pend_req_q.push_back(make_write(i, 8'h40 + i, i * 8 + 1, i[0], i, i[1], i[2]));

        // Directed: unmatched, skip, keep over skip, ending, wildcard, overflow
        pend_req_q.push_back(make_begin(0));
        pend_req_q.push_back(make_char(8'h61));
        pend_req_q.push_back(make_char(8'h20));
        pend_req_q.push_back(make_char(8'h78));
        pend_req_q.push_back(make_char(8'hFF));
        pend_req_q.push_back(make_char(8'h01));
        pend_req_q.push_back(make_char(8'h61));
        pend_req_q.push_back(make_char(8'h62));
        pend_req_q.push_back(make_char(8'h63));
        pend_req_q.push_back(make_char(8'h64));
        // Shadowed entry: the lower slot wins
        pend_req_q.push_back(make_char(8'h2C));
        pend_req_q.push_back(make_char(8'h80));
        pend_req_q.push_back(make_end());
        // End of input leaves the state alone
        pend_req_q.push_back(make_begin(8'hFF));
        pend_req_q.push_back(make_end());
        // Begin drops a partial token
        pend_req_q.push_back(make_begin(0));
        pend_req_q.push_back(make_char(8'h61));
        pend_req_q.push_back(make_char(8'h61));
        pend_req_q.push_back(make_begin(0));
        pend_req_q.push_back(make_char(8'h61));
        // Rewrite a live slot mid-stream
        pend_req_q.push_back(make_write(0, 0, 8'h20, 1'b0, 0, 1'b0, 1'b0));
        pend_req_q.push_back(make_char(8'h20));
        pend_req_q.push_back(make_char(8'h2C));
        pend_req_q.push_back(make_end());

        // Hold the receiver while the sender keeps offering
        random_phase(32, 64, 60, 1, 0);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;

        random_phase(0, 3, 25, 0, 0);
        random_phase(1, 1, 25, 0, 1);
        random_phase(63, 8, 40, 0, 0);
        random_phase(5, 0, 25, 1, 1);
        random_phase(32, 4096, 40, 0, 0);
        random_phase(17, 8191, 35, 0, 0);
        random_phase(32, 2, 40, 0, 0);
        random_phase(33, 16, 40, 1, 0);
        random_phase(12, 5, 40, 0, 0);
        random_phase(32, 32, 40, 0, 1);
        wait_idle();

        $display("covered %0d table writes, %0d begins, %0d characters, %0d end-of-input",
                 n_writes, n_begins, n_chars, n_ends);
        $display("over %0d register settings: %0d tokens closed by table, %0d overflows",
                 n_settings, n_tok_ends, n_overflow);
        if (err_cnt == 0 && token_exp_q.size() == 0)
            $display("table_driven_token_splitter test passed");
        else
            $display("table_driven_token_splitter test failed");
        $finish;
    end

endmodule
